[rtl/hole_fit_allocator_defines.svh]
// ---------------------------------------------------------------------------
// Hole fit allocator assertion macros
// Shared property wrappers for the checker; clocked, reset-qualified.
// ---------------------------------------------------------------------------
`ifndef HOLE_FIT_ALLOCATOR_DEFINES_SVH
`define HOLE_FIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define HFA_ASSERT_IMP(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HFA_ASSERT_NXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hfa_pkg.sv]
// ---------------------------------------------------------------------------
// hfa_pkg
// Shared widths, codes, state type and control/status structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hfa_pkg;

  // Default sizing
  localparam int DEF_MAX_HOLES = 16;
  localparam int DEF_SIZE_BITS = 16;

  // Port field widths
  localparam int IDX_W        = 4;
  localparam int VAL_W        = 16;
  localparam int MODE_W       = 2;
  localparam int HOLE_COUNT_W = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 5;

  // Commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  // Fit policies (code 3 behaves as first fit)
  localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLE_COUNT = 2'd1;

  // Register reset values
  localparam logic [MODE_W-1:0]       FIT_MODE_RST   = FIT_FIRST;
  localparam logic [HOLE_COUNT_W-1:0] HOLE_COUNT_RST = 5'd1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_SCAN,
    ST_UPDATE,
    ST_REPORT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic scan_run;
    logic write_load;
    logic write_alloc;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_alloc;
    logic scan_done;
    logic found;
  } sts_t;

endpackage

`default_nettype wire

[rtl/hfa_ram.sv]
// ---------------------------------------------------------------------------
// hfa_ram
// Generic one-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/hfa_ctrl.sv]
// ---------------------------------------------------------------------------
// hfa_ctrl
// Command sequencer: decode, load write, hole scan, update and report.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hfa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire hfa_pkg::sts_t sts,
  output hfa_pkg::ctl_t      ctl,
  output logic               busy,
  output logic               report
);

  hfa_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hfa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hfa_pkg::ST_IDLE: begin
        if (start) state_nxt = hfa_pkg::ST_DECODE;
      end
      hfa_pkg::ST_DECODE: begin
        state_nxt = sts.is_alloc ? hfa_pkg::ST_SCAN : hfa_pkg::ST_WRITE;
      end
      hfa_pkg::ST_WRITE: begin
        state_nxt = hfa_pkg::ST_REPORT;
      end
      hfa_pkg::ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = sts.found ? hfa_pkg::ST_UPDATE : hfa_pkg::ST_REPORT;
        end
      end
      hfa_pkg::ST_UPDATE: begin
        state_nxt = hfa_pkg::ST_REPORT;
      end
      hfa_pkg::ST_REPORT: begin
        state_nxt = hfa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = hfa_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    ctl             = '0;
    busy            = 1'b1;
    report          = 1'b0;
    case (state_r)
      hfa_pkg::ST_IDLE: begin
        busy        = 1'b0;
        ctl.capture = start;
      end
      hfa_pkg::ST_DECODE: begin
      end
      hfa_pkg::ST_WRITE: begin
        ctl.write_load = 1'b1;
      end
      hfa_pkg::ST_SCAN: begin
        ctl.scan_run = 1'b1;
      end
      hfa_pkg::ST_UPDATE: begin
        ctl.write_alloc = 1'b1;
      end
      hfa_pkg::ST_REPORT: begin
        report = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/hfa_datapath.sv]
// ---------------------------------------------------------------------------
// hfa_datapath
// Config registers, hole table, scan compare and result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hfa_datapath #(
  parameter int MAX_HOLES = hfa_pkg::DEF_MAX_HOLES,
  parameter int SIZE_BITS = hfa_pkg::DEF_SIZE_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_cmd,
  input  wire logic [hfa_pkg::IDX_W-1:0]        in_hole_index,
  input  wire logic [hfa_pkg::VAL_W-1:0]        in_size_value,
  input  wire logic                             cfg_we,
  input  wire logic [hfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [hfa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire hfa_pkg::ctl_t                    ctl,
  output hfa_pkg::sts_t                         sts,
  output logic                                  res_granted,
  output logic      [hfa_pkg::IDX_W-1:0]        res_chosen_hole,
  output logic      [hfa_pkg::VAL_W-1:0]        res_remaining
);

  localparam int AW = $clog2(MAX_HOLES);
  localparam int CW = $clog2(MAX_HOLES + 1);

  // Config registers
  logic [hfa_pkg::MODE_W-1:0]       fit_mode_r;
  logic [hfa_pkg::HOLE_COUNT_W-1:0] hole_count_r;

  // Captured command
  logic                      cmd_r;
  logic [hfa_pkg::IDX_W-1:0] idx_r;
  logic [SIZE_BITS-1:0]      val_r;

  // Scan state
  logic [CW-1:0]        scan_cnt_r;
  logic                 dv_r;
  logic                 found_r;
  logic [AW-1:0]        best_idx_r;
  logic [SIZE_BITS-1:0] best_size_r;

  // Table port signals
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [SIZE_BITS-1:0] ram_rdata;

  logic [31:0]          size_ext;
  logic [31:0]          idx_ext;
  logic [31:0]          val_ext;
  logic [31:0]          left_ext;
  logic [31:0]          best_ext;
  logic [31:0]          n_full;
  logic [CW-1:0]        n_use;
  logic                 issue;
  logic                 load_ok;
  logic [AW-1:0]        load_addr;
  logic [SIZE_BITS-1:0] left;
  logic                 fits;
  logic                 better;
  logic                 take;

  // Config write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r   <= hfa_pkg::FIT_MODE_RST;
      hole_count_r <= hfa_pkg::HOLE_COUNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == hfa_pkg::REG_FIT_MODE) begin
        fit_mode_r <= cfg_data[hfa_pkg::MODE_W-1:0];
      end
      if (cfg_index == hfa_pkg::REG_HOLE_COUNT) begin
        hole_count_r <= cfg_data[hfa_pkg::HOLE_COUNT_W-1:0];
      end
    end
  end

  // Width adaptation of fields against table sizing
  assign size_ext  = 32'(in_size_value);
  assign idx_ext   = 32'(idx_r);
  assign val_ext   = 32'(val_r);
  assign load_ok   = idx_ext < 32'(MAX_HOLES);
  assign load_addr = idx_ext[AW-1:0];
  assign left      = best_size_r - val_r;
  assign left_ext  = 32'(left);
  assign best_ext  = 32'(best_idx_r);

  // Entries in use, clipped to table depth
  assign n_full = (32'(hole_count_r) > 32'(MAX_HOLES)) ? 32'(MAX_HOLES) : 32'(hole_count_r);
  assign n_use  = n_full[CW-1:0];
  assign issue  = scan_cnt_r < n_use;

  // Capture beat
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= in_cmd;
      idx_r <= in_hole_index;
      val_r <= size_ext[SIZE_BITS-1:0];
    end
  end

  // Candidate compare on the entry read last cycle
  assign fits   = ram_rdata >= val_r;
  assign better = ((fit_mode_r == hfa_pkg::FIT_BEST)  && (ram_rdata < best_size_r)) ||
                  ((fit_mode_r == hfa_pkg::FIT_WORST) && (ram_rdata > best_size_r));
  assign take   = dv_r && fits && (!found_r || better);

  // Scan counter and read-data tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      dv_r       <= 1'b0;
      found_r    <= 1'b0;
    end else if (ctl.capture) begin
      scan_cnt_r <= '0;
      dv_r       <= 1'b0;
      found_r    <= 1'b0;
    end else if (ctl.scan_run) begin
      dv_r <= issue;
      if (issue) begin
        scan_cnt_r <= scan_cnt_r + CW'(1);
      end
      if (take) begin
        found_r <= 1'b1;
      end
    end
  end

  // Best candidate (index of data in flight is one behind the counter)
  always_ff @(posedge clk) begin
    if (ctl.scan_run && take) begin
      best_idx_r  <= AW'(scan_cnt_r - CW'(1));
      best_size_r <= ram_rdata;
    end
  end

  // Table access
  assign ram_we    = (ctl.write_load && load_ok) || ctl.write_alloc;
  assign ram_waddr = ctl.write_alloc ? best_idx_r : load_addr;
  assign ram_wdata = ctl.write_alloc ? left : val_r;
  assign ram_re    = ctl.scan_run && issue;

  hfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_HOLES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_cnt_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Result registers: cleared on capture, filled on success
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      res_granted     <= 1'b0;
      res_chosen_hole <= '0;
      res_remaining   <= '0;
    end else if (ctl.write_load && load_ok) begin
      res_granted     <= 1'b1;
      res_chosen_hole <= idx_r;
      res_remaining   <= val_ext[hfa_pkg::VAL_W-1:0];
    end else if (ctl.write_alloc) begin
      res_granted     <= 1'b1;
      res_chosen_hole <= best_ext[hfa_pkg::IDX_W-1:0];
      res_remaining   <= left_ext[hfa_pkg::VAL_W-1:0];
    end
  end

  // Status
  assign sts.is_alloc  = cmd_r == hfa_pkg::CMD_ALLOC;
  assign sts.scan_done = !issue && !dv_r;
  assign sts.found     = found_r;

endmodule

`default_nettype wire

[rtl/hole_fit_allocator.sv]
// ---------------------------------------------------------------------------
// hole_fit_allocator
// Free-hole table with first, best and worst fit allocation.
// ---------------------------------------------------------------------------
//
//   Channel  | Ports                                    | Handshake
//   ---------+------------------------------------------+------------------------
//   command  | start, busy, in_cmd/hole_index/size_value | beat on start && !busy
//   result   | out_valid, out_granted/chosen_hole/remaining | one-cycle strobe
//   config   | cfg_we, cfg_index, cfg_data              | write on cfg_we
//
// A load beat passes through decode, table write and report.
// An allocate beat passes through decode, the scan, an update of the chosen
// entry when a hole is granted, and report. The scan covers the first N entries,
// N = min(hole_count, MAX_HOLES); with N = 0 no entry is read. The
// scan reads one entry per cycle through the single RAM read port, and the
// compare works on the registered read data.
// busy stays high from the cycle after accept through the result strobe.
// Synchronous active-low reset returns to idle, fit_mode 0, hole_count 1.
// Results cannot be stalled; the strobe is held for exactly one cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hole_fit_allocator #(
  parameter int MAX_HOLES = hfa_pkg::DEF_MAX_HOLES,
  parameter int SIZE_BITS = hfa_pkg::DEF_SIZE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_cmd,
  input  wire logic [hfa_pkg::IDX_W-1:0]      in_hole_index,
  input  wire logic [hfa_pkg::VAL_W-1:0]      in_size_value,
  output logic                                out_valid,
  output logic                                out_granted,
  output logic      [hfa_pkg::IDX_W-1:0]      out_chosen_hole,
  output logic      [hfa_pkg::VAL_W-1:0]      out_remaining,
  input  wire logic                           cfg_we,
  input  wire logic [hfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [hfa_pkg::CFG_DATA_W-1:0] cfg_data
);

  hfa_pkg::ctl_t ctl;
  hfa_pkg::sts_t sts;

  // Sequencer
  hfa_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy),
    .report (out_valid)
  );

  // Table and scan datapath
  hfa_datapath #(
    .MAX_HOLES (MAX_HOLES),
    .SIZE_BITS (SIZE_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_hole_index   (in_hole_index),
    .in_size_value   (in_size_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .ctl             (ctl),
    .sts             (sts),
    .res_granted     (out_granted),
    .res_chosen_hole (out_chosen_hole),
    .res_remaining   (out_remaining)
  );

endmodule

`default_nettype wire

[rtl/hfa_checker.sv]
// ---------------------------------------------------------------------------
// hfa_checker
// Port-level checks on command/result sequencing, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hole_fit_allocator_defines.svh"

module hfa_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      out_valid,
  input wire logic                      out_granted,
  input wire logic [hfa_pkg::IDX_W-1:0] out_chosen_hole,
  input wire logic [hfa_pkg::VAL_W-1:0] out_remaining
);

  // An accepted beat makes the block busy
  `HFA_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept without busy")

  // A result only appears while a beat is in flight
  `HFA_ASSERT_IMP(a_result_busy, clk, rst_n, out_valid, busy, "result while idle")

  // One result per beat, then back to idle
  `HFA_ASSERT_NXT(a_result_once, clk, rst_n, out_valid, !out_valid && !busy, "result repeated")

  // A refused beat reports zero hole and zero size
  `HFA_ASSERT_IMP(a_refuse_zero, clk, rst_n, out_valid && !out_granted,
    (out_chosen_hole == '0) && (out_remaining == '0), "nonzero refused result")

endmodule

bind hole_fit_allocator hfa_checker u_hfa_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_granted     (out_granted),
  .out_chosen_hole (out_chosen_hole),
  .out_remaining   (out_remaining)
);

`default_nettype wire

[verif/hfa_grant_checker.sv]
// ---------------------------------------------------------------------------
// Hole fit allocator grant checker
// Follows command beats and register writes, keeps its own hole table and
// fit policy, and checks each result strobe field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hfa_grant_checker
  import hfa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_cmd,
  input  logic [IDX_W-1:0]      in_hole_index,
  input  logic [VAL_W-1:0]      in_size_value,
  input  logic                  out_valid,
  input  logic                  out_granted,
  input  logic [IDX_W-1:0]      out_chosen_hole,
  input  logic [VAL_W-1:0]      out_remaining,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    pending,
  output int                    fail_count
);

  localparam int HOLES = DEF_MAX_HOLES;

  typedef struct packed {
    logic             granted;
    logic [IDX_W-1:0] hole;
    logic [VAL_W-1:0] left;
  } grant_t;

  // Shadow copy of the block's table and registers
  logic [VAL_W-1:0]        hole_size [HOLES];
  logic [MODE_W-1:0]       fit_mode;
  logic [HOLE_COUNT_W-1:0] hole_count;
  grant_t                  pending_grants [$];

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    fail_count++;
  endtask

  // Apply one beat to the shadow table and return the result it must give
  function automatic grant_t serve_request(input logic cmd, input logic [IDX_W-1:0] idx,
                                           input logic [VAL_W-1:0] val);
    grant_t g;
    int     n;
    int     pick;
    bit     found;
    g     = '0;
    pick  = 0;
    found = 1'b0;
    if (cmd == CMD_LOAD) begin
      hole_size[idx] = val;
      g.granted = 1'b1;
      g.hole    = idx;
      g.left    = val;
      return g;
    end
    // Scan holes in use from index 0; ties keep the lower index
    n = (hole_count > HOLES) ? HOLES : hole_count;
    for (int i = 0; i < n; i++) begin
      if (hole_size[i] < val) continue;
      if (!found) begin
        found = 1'b1;
        pick  = i;
        if (fit_mode != FIT_BEST && fit_mode != FIT_WORST) break;
      end else if (fit_mode == FIT_BEST && hole_size[i] < hole_size[pick]) begin
        pick = i;
      end else if (fit_mode == FIT_WORST && hole_size[i] > hole_size[pick]) begin
        pick = i;
      end
    end
    if (found) begin
      hole_size[pick] = hole_size[pick] - val;
      g.granted = 1'b1;
      g.hole    = pick[IDX_W-1:0];
      g.left    = hole_size[pick];
    end
    return g;
  endfunction

  // Register writes, result compare, then beat capture
  always @(posedge clk) begin : watch
    grant_t want;
    if (!rst_n) begin
      fit_mode   = FIT_MODE_RST;
      hole_count = HOLE_COUNT_RST;
      for (int i = 0; i < HOLES; i++) hole_size[i] = '0;
      pending_grants.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FIT_MODE:   fit_mode = cfg_data[MODE_W-1:0];
          REG_HOLE_COUNT: hole_count = cfg_data[HOLE_COUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (pending_grants.size() == 0) begin
          report_mismatch("result strobe with no beat outstanding");
        end else begin
          want = pending_grants.pop_front();
          if (out_granted !== want.granted)
            report_mismatch($sformatf("granted %0b, want %0b", out_granted, want.granted));
          if (out_chosen_hole !== want.hole)
            report_mismatch($sformatf("chosen_hole %0d, want %0d", out_chosen_hole,
                                      want.hole));
          if (out_remaining !== want.left)
            report_mismatch($sformatf("remaining %0d, want %0d", out_remaining, want.left));
        end
      end
      if (start && !busy)
        pending_grants.push_back(serve_request(in_cmd, in_hole_index, in_size_value));
    end
    pending <= pending_grants.size();
  end

endmodule

[verif/hole_fit_allocator_test.sv]
// ---------------------------------------------------------------------------
// Hole fit allocator testbench
// Loads the whole hole table, runs a directed pass over every fit policy and
// hole count corner, then random load/allocate traffic in three sender gap
// profiles with the policy changed between blocks. The checker predicts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hole_fit_allocator_test;
  import hfa_pkg::*;

  localparam int HOLES        = DEF_MAX_HOLES;
  localparam int RUN_LIMIT    = 400000;
  localparam int DRAIN_CYCLES = 25;
  localparam int BLOCK_BEATS  = 40;

  // Policy code 3 is unassigned and falls back to first fit
  localparam logic [MODE_W-1:0] FIT_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  in_cmd = 1'b0;
  logic [IDX_W-1:0]      in_hole_index = '0;
  logic [VAL_W-1:0]      in_size_value = '0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  busy;
  logic                  out_valid;
  logic                  out_granted;
  logic [IDX_W-1:0]      out_chosen_hole;
  logic [VAL_W-1:0]      out_remaining;
  int                    pending;
  int                    fail_count;
  int                    cycles = 0;
  int                    idle_pct = 0;

  // Initial hole sizes: extremes, exact duplicates for ties, a zero hole
  logic [VAL_W-1:0] seed_sizes [HOLES] = '{
    16'hFFFF, 16'h0000, 16'h0001, 16'd100, 16'd300, 16'd100, 16'hFFFF, 16'h8000,
    16'h5555, 16'hAAAA, 16'd200, 16'd200, 16'd7, 16'd1000, 16'd50, 16'hFFFE
  };

  hole_fit_allocator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_hole_index   (in_hole_index),
    .in_size_value   (in_size_value),
    .out_valid       (out_valid),
    .out_granted     (out_granted),
    .out_chosen_hole (out_chosen_hole),
    .out_remaining   (out_remaining),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  hfa_grant_checker grant_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_hole_index   (in_hole_index),
    .in_size_value   (in_size_value),
    .out_valid       (out_valid),
    .out_granted     (out_granted),
    .out_chosen_hole (out_chosen_hole),
    .out_remaining   (out_remaining),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pending         (pending),
    .fail_count      (fail_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one beat until accepted; random gaps show noise on the fields
  task automatic send_beat(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      if ($urandom_range(0, 99) < idle_pct) begin
        start         <= 1'b0;
        in_cmd        <= 1'($urandom_range(0, 1));
        in_hole_index <= IDX_W'($urandom_range(0, HOLES - 1));
        in_size_value <= VAL_W'($urandom_range(0, 65535));
      end else begin
        start         <= 1'b1;
        in_cmd        <= cmd;
        in_hole_index <= idx;
        in_size_value <= val;
      end
      @(posedge clk);
      taken = start && !busy;
    end
  endtask

  // Drop start and wait until every result is back and the block is idle
  task automatic wait_idle;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_policy(input logic [MODE_W-1:0] mode,
                            input logic [HOLE_COUNT_W-1:0] count);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FIT_MODE;
    cfg_data  <= {{(CFG_DATA_W - MODE_W){1'b0}}, mode};
    @(posedge clk);
    cfg_index <= REG_HOLE_COUNT;
    cfg_data  <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly allocates, with refills; sizes lean to small values and ties
  task automatic send_random_beat;
    logic             cmd;
    logic [VAL_W-1:0] val;
    if ($urandom_range(0, 99) < 35) begin
      cmd = CMD_LOAD;
      case ($urandom_range(0, 7))
        0:       val = '0;
        1:       val = '1;
        2, 3:    val = VAL_W'(100 * $urandom_range(1, 4));
        4:       val = VAL_W'($urandom_range(1, 255));
        default: val = VAL_W'($urandom_range(0, 65535));
      endcase
    end else begin
      cmd = CMD_ALLOC;
      case ($urandom_range(0, 9))
        0:          val = '0;
        1:          val = '1;
        2, 3, 4, 5: val = VAL_W'($urandom_range(1, 255));
        6:          val = VAL_W'(100 * $urandom_range(1, 3));
        default:    val = VAL_W'($urandom_range(0, 65535));
      endcase
    end
    send_beat(cmd, IDX_W'($urandom_range(0, HOLES - 1)), val);
  endtask

  initial begin
    logic [HOLE_COUNT_W-1:0] count;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fill every entry so no scan reads an unloaded hole
    for (int i = 0; i < HOLES; i++) send_beat(CMD_LOAD, i[IDX_W-1:0], seed_sizes[i]);

    // Zero request, full-size request, exact fit under first fit
    set_policy(FIT_FIRST, HOLE_COUNT_W'(HOLES));
    send_beat(CMD_ALLOC, 4'hF, 16'h0000);
    send_beat(CMD_ALLOC, 4'h0, 16'hFFFF);
    send_beat(CMD_ALLOC, 4'h5, 16'd100);
    // Best fit with duplicate sizes
    set_policy(FIT_BEST, HOLE_COUNT_W'(HOLES));
    send_beat(CMD_ALLOC, 4'h0, 16'd150);
    send_beat(CMD_ALLOC, 4'h0, 16'd1);
    // Worst fit, then a request nothing can hold
    set_policy(FIT_WORST, HOLE_COUNT_W'(HOLES));
    send_beat(CMD_ALLOC, 4'h0, 16'd1);
    send_beat(CMD_ALLOC, 4'hA, 16'hFFFF);
    // Unused policy code, empty scan, oversize hole count
    set_policy(FIT_UNUSED, HOLE_COUNT_W'(HOLES));
    send_beat(CMD_ALLOC, 4'h0, 16'd7);
    set_policy(FIT_FIRST, 5'd0);
    send_beat(CMD_ALLOC, 4'h0, 16'h0000);
    set_policy(FIT_BEST, 5'd31);
    send_beat(CMD_ALLOC, 4'h0, 16'd2);

    // Random: three sender gap profiles, new policy every block
    for (int phase = 0; phase < 3; phase++) begin
      for (int blk = 0; blk < 5; blk++) begin
        case ($urandom_range(0, 9))
          0:       count = 5'd0;
          1:       count = 5'd1;
          2:       count = HOLE_COUNT_W'(HOLES);
          3:       count = 5'd31;
          4:       count = HOLE_COUNT_W'($urandom_range(HOLES + 1, 30));
          default: count = HOLE_COUNT_W'($urandom_range(2, HOLES - 1));
        endcase
        set_policy(MODE_W'($urandom_range(0, 3)), count);
        idle_pct = (phase == 0) ? 34 : (phase == 1) ? 46 : 0;
        repeat (BLOCK_BEATS) send_random_beat();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
